FILE: design/xoshiro256_generator_with_jump_assert.svh
// ----------------------------------------------------------------------------
// xoshiro256_generator_with_jump_assert.svh
// Assertion macros used by the checker of the generator.
// ----------------------------------------------------------------------------
`ifndef XOSHIRO256_GENERATOR_WITH_JUMP_ASSERT_SVH
`define XOSHIRO256_GENERATOR_WITH_JUMP_ASSERT_SVH

// checked on every clock edge outside of reset
`define XSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define XSR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/xsr_pkg.sv
// ----------------------------------------------------------------------------
// xsr_pkg
// Shared types and constants of the xoshiro256** generator with jump.
// ----------------------------------------------------------------------------
package xsr_pkg;

	// request kinds
	localparam logic [1:0] KIND_DRAW = 2'd0;
	localparam logic [1:0] KIND_LOAD = 2'd1;
	localparam logic [1:0] KIND_JUMP = 2'd2;

	// 2^128 jump polynomial, bit n of the vector is step n of the jump
	localparam logic [255:0] JUMP_POLY = {
		64'h39abdc4529b1661c, 64'ha9582618e03fc9aa,
		64'hd5a61266f0c9392c, 64'h180ec6d33cfd0aba
	};

	localparam int JUMP_STEPS = 256;

	// controller to datapath commands
	typedef struct packed {
		logic       load;        // write one state word
		logic       draw_start;  // advance state, start output scrambler
		logic       draw1;       // finish scrambler (times 9)
		logic       draw2;       // partial products of the bound
		logic       draw3;       // sum of partial products
		logic       jump_start;  // clear jump accumulator
		logic       jump_step;   // one jump step
		logic [7:0] jump_idx;    // polynomial bit for this step
		logic       jump_end;    // copy accumulator into state
		logic       out_load;    // load output register
		logic       out_draw;    // result comes from a draw
	} xsr_cmd_t;

endpackage

FILE: design/xoshiro256_generator_with_jump.sv
// One request at a time: a new request is taken only after the result of the
// last one is registered, and a stalled output keeps the sequencer waiting.
// A jump is made of 256 single state steps through the one update unit.
// Reset clears the sequencer and output valid; state words are undefined until loaded.
// ----------------------------------------------------------------------------
// xoshiro256_generator_with_jump
// xoshiro256** generator with word load, draw with fraction and bounded
// integer, and 2^128 jump.
// ----------------------------------------------------------------------------
module xoshiro256_generator_with_jump (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [1:0]  word_index,
	input  logic [63:0] load_value,
	input  logic [30:0] range_max,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] raw_value,
	output logic [51:0] unit_fraction,
	output logic [30:0] bounded_value
);
	import xsr_pkg::*;

	xsr_cmd_t cmd;

	// sequencer
	xsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// state and arithmetic
	xsr_datapath u_datapath (
		.clk           (clk),
		.cmd           (cmd),
		.word_index    (word_index),
		.load_value    (load_value),
		.range_max     (range_max),
		.raw_value     (raw_value),
		.unit_fraction (unit_fraction),
		.bounded_value (bounded_value)
	);

endmodule

FILE: design/xsr_datapath.sv
// ----------------------------------------------------------------------------
// xsr_datapath
// State words, jump accumulator, output scrambler, bound multiplier and
// output register of the generator.
// ----------------------------------------------------------------------------
module xsr_datapath (
	input  logic              clk,
	input  xsr_pkg::xsr_cmd_t cmd,
	input  logic [1:0]        word_index,
	input  logic [63:0]       load_value,
	input  logic [30:0]       range_max,
	output logic [63:0]       raw_value,
	output logic [51:0]       unit_fraction,
	output logic [30:0]       bounded_value
);
	import xsr_pkg::*;

	typedef logic [3:0][63:0] state_t;

	// one xoshiro256 state transition
	function automatic state_t advance(input state_t w);
		logic [63:0] shifted;
		logic [63:0] n0;
		logic [63:0] n1;
		logic [63:0] n2;
		logic [63:0] n3;
		state_t      r;
		shifted = {w[1][46:0], 17'b0};
		n2 = w[2] ^ w[0];
		n3 = w[3] ^ w[1];
		n1 = w[1] ^ n2;
		n0 = w[0] ^ n3;
		r[0] = n0;
		r[1] = n1;
		r[2] = n2 ^ shifted;
		r[3] = {n3[18:0], n3[63:19]};
		return r;
	endfunction

	state_t      words_q;
	state_t      acc_q;
	logic [63:0] t_q;
	logic [63:0] raw_q;
	logic [30:0] range_q;
	logic [56:0] pp_hi_q;
	logic [56:0] pp_lo_q;
	logic [56:0] part_q;
	logic [63:0] raw_value_q;
	logic [51:0] unit_fraction_q;
	logic [30:0] bounded_value_q;

	logic [63:0] rot_t;
	logic        poly_bit;

	assign rot_t    = {t_q[56:0], t_q[63:57]};
	assign poly_bit = JUMP_POLY[cmd.jump_idx];

	// state words: load, draw advance, jump steps, jump copy
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			words_q[word_index] <= load_value;
		end else if (cmd.draw_start || cmd.jump_step) begin
			words_q <= advance(words_q);
		end else if (cmd.jump_end) begin
			words_q <= acc_q;
		end
	end

	// jump accumulator
	always_ff @(posedge clk) begin
		if (cmd.jump_start) begin
			acc_q <= '0;
		end else if (cmd.jump_step && poly_bit) begin
			acc_q <= acc_q ^ words_q;
		end
	end

	// scrambler: w1 * 5, rotate by 7, times 9
	always_ff @(posedge clk) begin
		if (cmd.draw_start) begin
			t_q     <= words_q[1] + {words_q[1][61:0], 2'b0};
			range_q <= range_max;
		end
		if (cmd.draw1) begin
			raw_q <= rot_t + {rot_t[60:0], 3'b0};
		end
	end

	// bound: fraction split in two 26-bit halves times range
	always_ff @(posedge clk) begin
		if (cmd.draw2) begin
			pp_hi_q <= 57'(raw_q[63:38]) * 57'(range_q);
			pp_lo_q <= 57'(raw_q[37:12]) * 57'(range_q);
		end
		if (cmd.draw3) begin
			part_q <= pp_hi_q + 57'(pp_lo_q[56:26]);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_draw) begin
				raw_value_q     <= raw_q;
				unit_fraction_q <= raw_q[63:12];
				bounded_value_q <= part_q[56:26] + 31'd1;
			end else begin
				raw_value_q     <= '0;
				unit_fraction_q <= '0;
				bounded_value_q <= '0;
			end
		end
	end

	assign raw_value     = raw_value_q;
	assign unit_fraction = unit_fraction_q;
	assign bounded_value = bounded_value_q;

endmodule

FILE: design/xsr_ctrl.sv
// ----------------------------------------------------------------------------
// xsr_ctrl
// Sequencer of the generator: handshakes, draw steps, jump step count.
// ----------------------------------------------------------------------------
module xsr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        kind,
	output logic              out_valid,
	input  logic              out_stall,
	output xsr_pkg::xsr_cmd_t cmd
);
	import xsr_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DRAW1 = 3'd1;
	localparam logic [2:0] S_DRAW2 = 3'd2;
	localparam logic [2:0] S_DRAW3 = 3'd3;
	localparam logic [2:0] S_JUMP  = 3'd4;
	localparam logic [2:0] S_JEND  = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [7:0] cnt_q;
	logic       draw_q;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;
	logic       last_step;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign last_step = (cnt_q == 8'(JUMP_STEPS - 1));
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.jump_idx = cnt_q;
		cmd.out_draw = draw_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_DRAW: begin
							cmd.draw_start = 1'b1;
							state_d = S_DRAW1;
						end
						KIND_LOAD: begin
							cmd.load = 1'b1;
							state_d = S_DONE;
						end
						KIND_JUMP: begin
							cmd.jump_start = 1'b1;
							state_d = S_JUMP;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_DRAW1: begin
				cmd.draw1 = 1'b1;
				state_d = S_DRAW2;
			end
			S_DRAW2: begin
				cmd.draw2 = 1'b1;
				state_d = S_DRAW3;
			end
			S_DRAW3: begin
				cmd.draw3 = 1'b1;
				state_d = S_DONE;
			end
			S_JUMP: begin
				cmd.jump_step = 1'b1;
				if (last_step) begin
					state_d = S_JEND;
				end
			end
			S_JEND: begin
				cmd.jump_end = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state, jump counter, request kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			draw_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				draw_q <= (kind == KIND_DRAW);
				cnt_q  <= '0;
			end else if (cmd.jump_step) begin
				cnt_q <= cnt_q + 8'd1;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: design/xsr_checker.sv
// ----------------------------------------------------------------------------
// xsr_props
// Port-level checks of the generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "xoshiro256_generator_with_jump_assert.svh"

module xsr_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  kind,
	input logic [1:0]  word_index,
	input logic [63:0] load_value,
	input logic [30:0] range_max,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] raw_value,
	input logic [51:0] unit_fraction,
	input logic [30:0] bounded_value
);

	// no result shows during reset
	`XSR_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !out_valid, "result valid in reset")

	// a stalled result stays
	`XSR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(raw_value), "stalled result changed")

	// fraction is the top of the raw output
	`XSR_ASSERT(a_frac_raw, out_valid |-> unit_fraction == raw_value[63:12], "fraction mismatch")

	// one request in flight: an accept is followed by a stall
	`XSR_ASSERT(a_one_inflight, in_valid && !in_stall |=> in_stall, "second request taken")

	// zero raw output gives bound 1 on a draw or 0 otherwise
	`XSR_ASSERT(a_zero_bound, out_valid && raw_value == 64'd0 |-> bounded_value <= 31'd1, "bad bound for zero")

endmodule

bind xoshiro256_generator_with_jump xsr_props u_xsr_props (.*);
